// ===== hdl/yazd_pkg.sv =====
// Shared types, constants and angle helpers for the yaw auto-zero drift trim.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps

package yazd_pkg;

  localparam int ANGLE_FRAC_BITS = 8;
  localparam int HALF_TURN       = 180 << ANGLE_FRAC_BITS;
  localparam int FULL_TURN       = 360 << ANGLE_FRAC_BITS;
  localparam bit ENABLE_TRIM_DEF = 1'b1;

  localparam int ANGLE_W     = 17;
  localparam int TIME_W      = 32;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 20;
  localparam int IN_TDATA_W  = 88;
  localparam int OUT_TDATA_W = 136;
  localparam int DIV_W       = 32;
  localparam int DIV_CNT_W   = $clog2(DIV_W);
  localparam int MS_PER_S    = 1000;

  // Wide enough for any sum or difference of two angles plus a correction
  localparam int WRAP_W     = 20;
  localparam int WRAP_ITERS = ((1 << 18) + FULL_TURN - 1) / FULL_TURN;

  typedef logic signed [WRAP_W-1:0] wrap_t;

  localparam wrap_t HALF_W = wrap_t'(HALF_TURN);
  localparam wrap_t FULL_W = wrap_t'(FULL_TURN);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_START_DELAY  = 3'd0,
    REG_STILL_WINDOW = 3'd1,
    REG_DEADBAND     = 3'd2,
    REG_MAX_ERROR    = 3'd3,
    REG_GAIN         = 3'd4,
    REG_MAX_STEP     = 3'd5,
    REG_MAX_TILT     = 3'd6,
    REG_MAX_YAW      = 3'd7
  } cfg_reg_t;

  typedef struct packed {
    logic [19:0] start_delay;
    logic [19:0] still_window;
    logic [15:0] deadband;
    logic [15:0] max_error;
    logic [16:0] gain;
    logic [15:0] max_step;
    logic [15:0] max_tilt;
    logic [16:0] max_yaw;
  } cfg_t;

  typedef struct packed {
    logic load;
    logic st1;
    logic st2;
    logic st3;
    logic div_step;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic st1_more;
    logic st2_more;
    logic st3_div;
    logic div_last;
  } status_t;

  // Map into [-HALF_TURN, HALF_TURN) by repeated full-turn steps
  function automatic wrap_t wrap_half(wrap_t d);
    wrap_t r;
    r = d;
    for (int i = 0; i < WRAP_ITERS; i++) begin
      if (r >= HALF_W) r = r - FULL_W;
      else if (r < -HALF_W) r = r + FULL_W;
    end
    return r;
  endfunction

  function automatic logic [WRAP_W-1:0] abs_w(wrap_t d);
    return d[WRAP_W-1] ? $unsigned(-d) : $unsigned(d);
  endfunction

endpackage

// ===== hdl/yazd_cfg.sv =====
// Configuration register file for the yaw trim; one write beat per register.
// Depends on yazd_pkg.
`timescale 1ns / 1ps

module yazd_cfg import yazd_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output cfg_t                  cfg
);

  cfg_t cfg_r;

  assign cfg_ready = 1'b1;
  assign cfg       = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.start_delay  <= '0;
      cfg_r.still_window <= '0;
      cfg_r.deadband     <= '0;
      cfg_r.max_error    <= 16'(HALF_TURN);
      cfg_r.gain         <= '0;
      cfg_r.max_step     <= 16'(HALF_TURN);
      cfg_r.max_tilt     <= 16'(HALF_TURN);
      cfg_r.max_yaw      <= 17'(FULL_TURN);
    end else if (cfg_valid) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_START_DELAY:  cfg_r.start_delay  <= cfg_data;
        REG_STILL_WINDOW: cfg_r.still_window <= cfg_data;
        REG_DEADBAND:     cfg_r.deadband     <= cfg_data[15:0];
        REG_MAX_ERROR:    cfg_r.max_error    <= cfg_data[15:0];
        REG_GAIN:         cfg_r.gain         <= cfg_data[16:0];
        REG_MAX_STEP:     cfg_r.max_step     <= cfg_data[15:0];
        REG_MAX_TILT:     cfg_r.max_tilt     <= cfg_data[15:0];
        REG_MAX_YAW:      cfg_r.max_yaw      <= cfg_data[16:0];
        default: ;
      endcase
    end
  end

endmodule

// ===== hdl/yazd_ctrl.sv =====
// Sequencer for the yaw trim: walks one beat through its stages and the divider.
// Depends on yazd_pkg.
`timescale 1ns / 1ps

module yazd_ctrl import yazd_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_tvalid,
  output logic    in_tready,
  output logic    out_tvalid,
  input  logic    out_tready,
  input  status_t sts,
  output cmd_t    cmd
);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_ST1  = 6'b000010,
    S_ST2  = 6'b000100,
    S_ST3  = 6'b001000,
    S_DIV  = 6'b010000,
    S_EMIT = 6'b100000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   slot_free;

  assign slot_free  = !out_valid_r || out_tready;
  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;

  always_comb begin
    cmd          = '0;
    cmd.load     = in_tvalid && in_tready;
    cmd.st1      = (state_r == S_ST1);
    cmd.st2      = (state_r == S_ST2);
    cmd.st3      = (state_r == S_ST3);
    cmd.div_step = (state_r == S_DIV);
    cmd.emit     = (state_r == S_EMIT) && slot_free;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (in_tvalid) state_nxt = S_ST1;
      S_ST1:  state_nxt = sts.st1_more ? S_ST2 : S_EMIT;
      S_ST2:  state_nxt = sts.st2_more ? S_ST3 : S_EMIT;
      S_ST3:  state_nxt = sts.st3_div ? S_DIV : S_EMIT;
      S_DIV:  if (sts.div_last) state_nxt = S_EMIT;
      S_EMIT: if (slot_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    if (cmd.emit) out_valid_nxt = 1'b1;
    else if (out_tready) out_valid_nxt = 1'b0;
    else out_valid_nxt = out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ===== hdl/yazd_dp.sv =====
// Datapath of the yaw trim: trim state, span tracking, correction and the
// serial rate divider. Depends on yazd_pkg.
`timescale 1ns / 1ps

module yazd_dp import yazd_pkg::*; #(
  parameter bit ENABLE_TRIM = ENABLE_TRIM_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  cfg_t                      cfg,
  input  cmd_t                      cmd,
  output status_t                   sts,
  input  logic                      in_mode,
  input  logic signed [ANGLE_W-1:0] in_roll,
  input  logic signed [ANGLE_W-1:0] in_pitch,
  input  logic signed [ANGLE_W-1:0] in_yaw,
  input  logic [TIME_W-1:0]         in_time,
  output logic signed [ANGLE_W-1:0] zero_yaw,
  output logic                      still_locked,
  output logic [TIME_W-1:0]         still_ms,
  output logic [15:0]               update_count,
  output logic signed [31:0]        correction_total,
  output logic signed [31:0]        bias_rate
);

  // latched beat
  logic                      mode_r;
  logic signed [ANGLE_W-1:0] roll_r, pitch_r, yaw_r;
  logic [TIME_W-1:0]         time_r;

  // trim state
  logic                      applied_r, prev_valid_r, win_active_r, still_r, last_valid_r;
  logic [TIME_W-1:0]         apply_time_r, win_start_r, still_time_r, last_time_r;
  logic signed [ANGLE_W-1:0] ref_r, prev_roll_r, prev_pitch_r, prev_yaw_r;
  logic signed [ANGLE_W-1:0] rmin_r, rmax_r, pmin_r, pmax_r;
  logic signed [31:0]        yu_r, ymin_r, ymax_r, sum_r, rate_r;
  logic [15:0]               updates_r;

  // stage registers
  logic              step_big_r, err_neg_r;
  logic [15:0]       aerr_r;
  logic [32:0]       prod_r;
  logic [DIV_W-1:0]  rem_r, quo_r, den_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic              rneg_r;

  // output beat
  logic signed [ANGLE_W-1:0] o_ref_r;
  logic                      o_still_r;
  logic [TIME_W-1:0]         o_still_time_r;
  logic [15:0]               o_updates_r;
  logic signed [31:0]        o_sum_r, o_rate_r;

  // stage 1
  wrap_t              dr, dp, dy, err;
  logic [WRAP_W-1:0]  aerr_w;
  logic signed [32:0] yu_sum;
  logic signed [31:0] yu_sat, y_ext;
  logic               in_delay, active, step_big;

  assign y_ext    = 32'(yaw_r);
  assign dr       = wrap_t'(roll_r) - wrap_t'(prev_roll_r);
  assign dp       = wrap_t'(pitch_r) - wrap_t'(prev_pitch_r);
  assign dy       = wrap_half(wrap_t'(yaw_r) - wrap_t'(prev_yaw_r));
  assign err      = wrap_half(wrap_t'(yaw_r) - wrap_t'(ref_r));
  assign aerr_w   = abs_w(err);
  assign yu_sum   = 33'(yu_r) + 33'(dy);
  assign yu_sat   = (yu_sum > 33'sh07FFFFFFF) ? 32'sh7FFFFFFF :
                    (yu_sum < -33'sh080000000) ? 32'sh80000000 : yu_sum[31:0];
  assign in_delay = (time_r - apply_time_r) < TIME_W'(cfg.start_delay);
  assign active   = !mode_r && ENABLE_TRIM && applied_r && !in_delay;
  assign step_big = (abs_w(dr) > WRAP_W'(cfg.max_step)) ||
                    (abs_w(dp) > WRAP_W'(cfg.max_step)) ||
                    (abs_w(dy) > WRAP_W'(cfg.max_step));

  // stage 2: window spans
  logic signed [ANGLE_W-1:0] rmin_n, rmax_n, pmin_n, pmax_n;
  logic signed [31:0]        ymin_n, ymax_n;
  logic signed [ANGLE_W:0]   rspan, pspan;
  logic signed [32:0]        yspan;
  logic                      span_bad, still_n, in_band;
  logic [TIME_W-1:0]         still_t;

  assign rmin_n   = (roll_r < rmin_r) ? roll_r : rmin_r;
  assign rmax_n   = (roll_r > rmax_r) ? roll_r : rmax_r;
  assign pmin_n   = (pitch_r < pmin_r) ? pitch_r : pmin_r;
  assign pmax_n   = (pitch_r > pmax_r) ? pitch_r : pmax_r;
  assign ymin_n   = (yu_r < ymin_r) ? yu_r : ymin_r;
  assign ymax_n   = (yu_r > ymax_r) ? yu_r : ymax_r;
  assign rspan    = (ANGLE_W+1)'(rmax_n) - (ANGLE_W+1)'(rmin_n);
  assign pspan    = (ANGLE_W+1)'(pmax_n) - (ANGLE_W+1)'(pmin_n);
  assign yspan    = 33'(ymax_n) - 33'(ymin_n);
  assign span_bad = ($unsigned(rspan) > (ANGLE_W+1)'(cfg.max_tilt)) ||
                    ($unsigned(pspan) > (ANGLE_W+1)'(cfg.max_tilt)) ||
                    ($unsigned(yspan) > 33'(cfg.max_yaw));
  assign still_t  = time_r - win_start_r;
  assign still_n  = still_t >= TIME_W'(cfg.still_window);
  assign in_band  = !(aerr_r < cfg.deadband) && !(aerr_r > cfg.max_error);

  // stage 3: correction, rounded half away from zero
  logic [33:0]        prod_rnd;
  logic [17:0]        corr_mag;
  logic signed [18:0] corr;
  logic signed [32:0] sum_add;
  logic signed [31:0] sum_sat;
  logic [TIME_W-1:0]  dt;
  wrap_t              ref_n;

  assign prod_rnd = 34'(prod_r) + 34'd32768;
  assign corr_mag = prod_rnd[33:16];
  assign corr     = err_neg_r ? -$signed({1'b0, corr_mag}) : $signed({1'b0, corr_mag});
  assign ref_n    = wrap_half(wrap_t'(ref_r) + wrap_t'(corr));
  assign sum_add  = 33'(sum_r) + 33'(corr);
  assign sum_sat  = (sum_add > 33'sh07FFFFFFF) ? 32'sh7FFFFFFF :
                    (sum_add < -33'sh080000000) ? 32'sh80000000 : sum_add[31:0];
  assign dt       = last_valid_r ? (time_r - last_time_r) : '0;

  // divider step
  logic [DIV_W:0]   trial;
  logic             qbit;
  logic [DIV_W-1:0] quo_n;

  assign trial = {rem_r, quo_r[DIV_W-1]};
  assign qbit  = trial >= {1'b0, den_r};
  assign quo_n = {quo_r[DIV_W-2:0], qbit};

  assign sts.st1_more = active && prev_valid_r;
  assign sts.st2_more = !step_big_r && win_active_r && !span_bad && still_n && in_band;
  assign sts.st3_div  = (dt != '0);
  assign sts.div_last = (cnt_r == DIV_CNT_W'(DIV_W - 1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      applied_r    <= 1'b0;
      ref_r        <= '0;
      prev_valid_r <= 1'b0;
      win_active_r <= 1'b0;
      still_r      <= 1'b0;
      still_time_r <= '0;
      updates_r    <= '0;
      sum_r        <= '0;
      last_valid_r <= 1'b0;
      rate_r       <= '0;
    end else begin
      if (cmd.load) begin
        mode_r  <= in_mode;
        roll_r  <= in_roll;
        pitch_r <= in_pitch;
        yaw_r   <= in_yaw;
        time_r  <= in_time;
      end

      if (cmd.st1) begin
        if (mode_r || (ENABLE_TRIM && applied_r && in_delay)) begin
          prev_valid_r <= 1'b0;
          win_active_r <= 1'b0;
          still_r      <= 1'b0;
          still_time_r <= '0;
          updates_r    <= '0;
          sum_r        <= '0;
          last_valid_r <= 1'b0;
          if (mode_r) begin
            ref_r        <= ANGLE_W'(wrap_half(wrap_t'(yaw_r)));
            applied_r    <= 1'b1;
            apply_time_r <= time_r;
          end
        end else if (active) begin
          prev_roll_r  <= roll_r;
          prev_pitch_r <= pitch_r;
          prev_yaw_r   <= yaw_r;
          prev_valid_r <= 1'b1;
          if (!prev_valid_r) begin
            // first sample after the delay opens the window
            yu_r         <= y_ext;
            win_active_r <= 1'b1;
            win_start_r  <= time_r;
            rmin_r <= roll_r;  rmax_r <= roll_r;
            pmin_r <= pitch_r; pmax_r <= pitch_r;
            ymin_r <= y_ext;   ymax_r <= y_ext;
            still_r      <= 1'b0;
            still_time_r <= '0;
          end else begin
            yu_r       <= yu_sat;
            step_big_r <= step_big;
            err_neg_r  <= err[WRAP_W-1];
            aerr_r     <= aerr_w[15:0];
            prod_r     <= 33'(aerr_w[15:0]) * 33'(cfg.gain);
          end
        end
      end

      if (cmd.st2) begin
        if (step_big_r || !win_active_r || span_bad) begin
          win_active_r <= 1'b1;
          win_start_r  <= time_r;
          rmin_r <= roll_r;  rmax_r <= roll_r;
          pmin_r <= pitch_r; pmax_r <= pitch_r;
          ymin_r <= yu_r;    ymax_r <= yu_r;
          still_r      <= 1'b0;
          still_time_r <= '0;
        end else begin
          rmin_r <= rmin_n; rmax_r <= rmax_n;
          pmin_r <= pmin_n; pmax_r <= pmax_n;
          ymin_r <= ymin_n; ymax_r <= ymax_n;
          still_time_r <= still_t;
          still_r      <= still_n;
          if (still_n && !in_band) rate_r <= '0;
        end
      end

      if (cmd.st3) begin
        ref_r        <= ANGLE_W'(ref_n);
        sum_r        <= sum_sat;
        if (updates_r != 16'hFFFF) updates_r <= updates_r + 16'd1;
        last_time_r  <= time_r;
        last_valid_r <= 1'b1;
        if (dt == '0) rate_r <= '0;
        // numerator: |corr| * 1000 + dt / 2, always below 2^32
        rem_r  <= '0;
        quo_r  <= DIV_W'(corr_mag) * DIV_W'(MS_PER_S) + {1'b0, dt[TIME_W-1:1]};
        den_r  <= dt;
        rneg_r <= err_neg_r;
        cnt_r  <= '0;
      end

      if (cmd.div_step) begin
        rem_r <= qbit ? DIV_W'(trial - {1'b0, den_r}) : trial[DIV_W-1:0];
        quo_r <= quo_n;
        cnt_r <= cnt_r + 1'b1;
        // quotient stays under 2^27, so no saturation is needed
        if (sts.div_last) rate_r <= rneg_r ? -$signed(quo_n) : $signed(quo_n);
      end

      if (cmd.emit) begin
        o_ref_r        <= ref_r;
        o_still_r      <= still_r;
        o_still_time_r <= still_time_r;
        o_updates_r    <= updates_r;
        o_sum_r        <= sum_r;
        o_rate_r       <= rate_r;
      end
    end
  end

  assign zero_yaw         = o_ref_r;
  assign still_locked     = o_still_r;
  assign still_ms         = o_still_time_r;
  assign update_count     = o_updates_r;
  assign correction_total = o_sum_r;
  assign bias_rate        = o_rate_r;

endmodule

// ===== hdl/yaw_auto_zero_drift_trim.sv =====
// Top level of the yaw auto-zero drift trim: stream ports, config port, wiring.
// Depends on yazd_pkg, yazd_cfg, yazd_ctrl and yazd_dp.
`timescale 1ns / 1ps

// Takes one beat at a time. A beat that ends in the first stage (an apply, a
// sample before any apply, inside the start delay or with trim disabled, the
// first sample after the delay) goes straight to the output register; a sample
// that goes through the window stage without trimming leaves after it; a trim
// also passes the correction stage and, when time has passed since an earlier
// update, the 32-step radix-2 divider that forms the bias rate. The next beat
// is taken from the cycle after the result lands in the output register, even
// while it waits to be read. Angles are 1/256 degree.
module yaw_auto_zero_drift_trim import yazd_pkg::*; #(
  parameter bit ENABLE_TRIM = ENABLE_TRIM_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // roll[16:0], pitch[33:17], yaw[50:34], time_ms[82:51], zero pad
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  // mode
  input  logic                   in_tuser,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // zero_yaw[16:0], still_locked[17], still_ms[49:18], update_count[65:50],
  // correction_total[97:66], bias_rate[129:98], zero pad
  output logic [OUT_TDATA_W-1:0] out_tdata,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  cfg_t    cfg;
  cmd_t    cmd;
  status_t sts;

  logic signed [ANGLE_W-1:0] zero_yaw;
  logic                      still_locked;
  logic [TIME_W-1:0]         still_ms;
  logic [15:0]               update_count;
  logic signed [31:0]        correction_total, bias_rate;

  yazd_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  yazd_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  yazd_dp #(
    .ENABLE_TRIM (ENABLE_TRIM)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg              (cfg),
    .cmd              (cmd),
    .sts              (sts),
    .in_mode          (in_tuser),
    .in_roll          (in_tdata[16:0]),
    .in_pitch         (in_tdata[33:17]),
    .in_yaw           (in_tdata[50:34]),
    .in_time          (in_tdata[82:51]),
    .zero_yaw         (zero_yaw),
    .still_locked     (still_locked),
    .still_ms         (still_ms),
    .update_count     (update_count),
    .correction_total (correction_total),
    .bias_rate        (bias_rate)
  );

  assign out_tdata = {6'b0, bias_rate, correction_total, update_count,
                      still_ms, still_locked, zero_yaw};

  // one beat in flight: no second beat taken right behind the first
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("beat accepted while previous still in progress");

  // reference always shown wrapped to a half turn
  a_ref_wrapped: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ($signed(out_tdata[16:0]) >= -HALF_TURN &&
                    $signed(out_tdata[16:0]) < HALF_TURN))
    else $error("zero_yaw outside half-turn range");

endmodule
